/* design/rsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, command and register codes, and the 2^(-i/256) table.
// ----------------------------------------------------------------------------
package rsp_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FEAT_WR,
    S_DIST,
    S_DIST_END,
    S_GAMMA,
    S_KEXP,
    S_KWAIT,
    S_DEC,
    S_PMUL,
    S_PARG,
    S_PEXP,
    S_PWAIT,
    S_DIVST,
    S_DWAIT,
    S_OUT
  } state_t;

  localparam logic [2:0] CMD_MEAN    = 3'd0;
  localparam logic [2:0] CMD_RECIP   = 3'd1;
  localparam logic [2:0] CMD_VECTOR  = 3'd2;
  localparam logic [2:0] CMD_COEF    = 3'd3;
  localparam logic [2:0] CMD_FEATURE = 3'd4;

  localparam logic [1:0] REG_GAMMA     = 2'd0;
  localparam logic [1:0] REG_INTERCEPT = 2'd1;
  localparam logic [1:0] REG_PLATT_A   = 2'd2;
  localparam logic [1:0] REG_PLATT_B   = 2'd3;

  // log2(e) in Q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef logic [30:0] exp_tab_t [256];

  // T[0] = 2^30, T[i+1] = round(T[i] * 2^(-1/256)) in Q1.30
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] v;
    exp_tab_t    t;
    v = 64'd1 << 30;
    for (int i = 0; i < 256; i++) begin
      t[i] = v[30:0];
      v    = (v * 64'd4283354012 + 64'd2147483648) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* design/rbf_svm_probability.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_svm_probability
// RBF support vector classifier with Platt probability output.
// ----------------------------------------------------------------------------
// Load items are written into their stores as they are accepted. A feature
// item first reads the stores, then is normalized and written. The feature
// at index NUM_FEATURES-1 starts a classification, during which item_stall
// stays high: the distance loop reads one support vector element per cycle,
// each vector then goes through the gamma multiply and the shared three-stage
// exp unit, and the Platt step reuses that exp unit and a 34-step bit-serial
// divider. The result sits in an output register; the next item is taken
// while it waits, but a new result is not loaded until the pending one has
// been transferred. Stores come up undefined and need no clearing after reset.
// ----------------------------------------------------------------------------
module rbf_svm_probability #(
  parameter int NUM_FEATURES = 8,
  parameter int NUM_VECTORS  = 64
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         cmd,
  input  logic [5:0]         feature_index,
  input  logic [9:0]         vector_index,
  input  logic signed [15:0] value,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [15:0]        probability,
  output logic signed [31:0] decision,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int FW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int VW  = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam int VAW = (NUM_VECTORS * NUM_FEATURES > 1) ?
                       $clog2(NUM_VECTORS * NUM_FEATURES) : 1;

  rsp_pkg::state_t state, state_next;

  // configuration
  logic [15:0]        gamma;
  logic signed [31:0] intercept;
  logic signed [31:0] platt_a;
  logic signed [31:0] platt_b;

  // stores
  logic signed [15:0] mean_mem  [NUM_FEATURES];
  logic signed [15:0] recip_mem [NUM_FEATURES];
  logic signed [15:0] norm_mem  [NUM_FEATURES];
  logic signed [15:0] vec_mem   [NUM_VECTORS * NUM_FEATURES];
  logic signed [15:0] coef_mem  [NUM_VECTORS];

  logic signed [15:0] mean_rd, recip_rd, norm_rd, vec_rd, coef_rd;

  logic               accept;
  logic               fok, vok;
  logic [16:0]        vaddr_full;
  logic [FW-1:0]      fi_r;
  logic signed [15:0] val_r;

  // loop counters
  logic [FW-1:0]      f_cnt;
  logic [VW-1:0]      v_cnt;
  logic [VAW-1:0]     rd_addr;
  logic               rd_vld;

  // datapath registers
  logic [38:0]        sq_dist;
  logic [54:0]        t;
  logic signed [47:0] acc;
  logic signed [31:0] dec;
  logic signed [63:0] pprod;
  logic signed [48:0] e;
  logic [16:0]        q;
  logic [15:0]        p;

  // normalization
  logic signed [16:0] ndiff;
  logic signed [32:0] nprod;
  logic signed [33:0] nsum;
  logic signed [21:0] nsh;
  logic signed [15:0] nsat;

  // distance
  logic signed [16:0] d;
  logic signed [33:0] dsq;

  // kernel and Platt arguments
  logic [54:0]        tr;
  logic [26:0]        kx;
  logic [48:0]        emag;
  logic [26:0]        px;

  // decision
  logic signed [47:0] dsum;
  logic signed [35:0] dsh;
  logic signed [31:0] dsat;
  logic signed [33:0] mac;
  logic signed [63:0] pps;

  // shared units
  logic               exp_start, exp_done;
  logic [26:0]        exp_x;
  logic [16:0]        exp_y;
  logic               div_start, div_done;
  logic [33:0]        div_num;
  logic [17:0]        div_den;
  logic [16:0]        div_q;

  logic               f_last, v_last;
  logic               out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != rsp_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign fok        = 7'(feature_index) < 7'(NUM_FEATURES);
  assign vok        = 11'(vector_index) < 11'(NUM_VECTORS);
  assign vaddr_full = 17'(vector_index) * 17'(NUM_FEATURES) + 17'(feature_index);

  assign f_last   = (f_cnt == FW'(NUM_FEATURES - 1));
  assign v_last   = (v_cnt == VW'(NUM_VECTORS - 1));
  assign out_free = !result_valid || !result_stall;

  // --- configuration registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma     <= '0;
      intercept <= '0;
      platt_a   <= '0;
      platt_b   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsp_pkg::REG_GAMMA:     gamma     <= cfg_data[15:0];
        rsp_pkg::REG_INTERCEPT: intercept <= cfg_data;
        rsp_pkg::REG_PLATT_A:   platt_a   <= cfg_data;
        rsp_pkg::REG_PLATT_B:   platt_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- stores: one write, one registered read each ---
  always_ff @(posedge clk) begin
    if (accept && fok && cmd == rsp_pkg::CMD_MEAN)
      mean_mem[feature_index[FW-1:0]] <= value;
    if (accept && fok && cmd == rsp_pkg::CMD_RECIP)
      recip_mem[feature_index[FW-1:0]] <= value;
    mean_rd  <= mean_mem[feature_index[FW-1:0]];
    recip_rd <= recip_mem[feature_index[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && fok && vok && cmd == rsp_pkg::CMD_VECTOR)
      vec_mem[vaddr_full[VAW-1:0]] <= value;
    vec_rd <= vec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && vok && cmd == rsp_pkg::CMD_COEF)
      coef_mem[vector_index[VW-1:0]] <= value;
    coef_rd <= coef_mem[v_cnt];
  end

  always_ff @(posedge clk) begin
    if (state == rsp_pkg::S_FEAT_WR)
      norm_mem[fi_r] <= nsat;
    norm_rd <= norm_mem[f_cnt];
  end

  // --- arithmetic ---
  // (value - mean) * recip, round at bit 12, saturate to Q4.12
  assign ndiff = 17'(val_r) - 17'(mean_rd);
  assign nprod = ndiff * 33'(recip_rd);
  assign nsum  = 34'(nprod) + 34'sd2048;
  assign nsh   = nsum[33:12];
  assign nsat  = (nsh > 22'sd32767)  ? 16'sh7FFF :
                 (nsh < -22'sd32768) ? 16'sh8000 : nsh[15:0];

  assign d   = 17'(norm_rd) - 17'(vec_rd);
  assign dsq = d * d;

  assign tr = t + (55'd1 << 23);
  assign kx = (tr[54:24] > 31'd67108864) ? 27'd67108864 : tr[50:24];

  assign emag = e[48] ? 49'(-e) : 49'(e);
  assign px   = (emag > 49'd67108864) ? 27'd67108864 : emag[26:0];

  assign mac  = coef_rd * $signed({1'b0, exp_y});

  assign dsum = acc + 48'sd2048;
  assign dsh  = dsum[47:12];
  assign dsat = (dsh > 36'sd2147483647)  ? 32'sh7FFFFFFF :
                (dsh < -36'sd2147483648) ? 32'sh80000000 : dsh[31:0];

  assign pps = pprod + 64'sd32768;

  assign exp_x   = (state == rsp_pkg::S_PEXP) ? px : kx;
  assign div_den = 18'd65536 + 18'(q);
  assign div_num = (!e[48] && e != '0) ? ({q, 16'd0} + 34'(div_den >> 1))
                                       : ((34'd1 << 32) + 34'(div_den >> 1));

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    exp_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      rsp_pkg::S_IDLE: begin
        if (accept && fok && cmd == rsp_pkg::CMD_FEATURE)
          state_next = rsp_pkg::S_FEAT_WR;
      end
      rsp_pkg::S_FEAT_WR: begin
        state_next = (fi_r == FW'(NUM_FEATURES - 1)) ? rsp_pkg::S_DIST
                                                      : rsp_pkg::S_IDLE;
      end
      rsp_pkg::S_DIST: begin
        if (f_last)
          state_next = rsp_pkg::S_DIST_END;
      end
      rsp_pkg::S_DIST_END: state_next = rsp_pkg::S_GAMMA;
      rsp_pkg::S_GAMMA:    state_next = rsp_pkg::S_KEXP;
      rsp_pkg::S_KEXP: begin
        exp_start  = 1'b1;
        state_next = rsp_pkg::S_KWAIT;
      end
      rsp_pkg::S_KWAIT: begin
        if (exp_done)
          state_next = v_last ? rsp_pkg::S_DEC : rsp_pkg::S_DIST;
      end
      rsp_pkg::S_DEC:  state_next = rsp_pkg::S_PMUL;
      rsp_pkg::S_PMUL: state_next = rsp_pkg::S_PARG;
      rsp_pkg::S_PARG: state_next = rsp_pkg::S_PEXP;
      rsp_pkg::S_PEXP: begin
        exp_start  = 1'b1;
        state_next = rsp_pkg::S_PWAIT;
      end
      rsp_pkg::S_PWAIT: begin
        if (exp_done)
          state_next = rsp_pkg::S_DIVST;
      end
      rsp_pkg::S_DIVST: begin
        div_start  = 1'b1;
        state_next = rsp_pkg::S_DWAIT;
      end
      rsp_pkg::S_DWAIT: begin
        if (div_done)
          state_next = rsp_pkg::S_OUT;
      end
      rsp_pkg::S_OUT: begin
        if (out_free)
          state_next = rsp_pkg::S_IDLE;
      end
      default: state_next = rsp_pkg::S_IDLE;
    endcase
  end

  // loop control
  always_ff @(posedge clk) begin
    if (rst) begin
      f_cnt   <= '0;
      v_cnt   <= '0;
      rd_addr <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= (state == rsp_pkg::S_DIST);
      if (state == rsp_pkg::S_FEAT_WR) begin
        f_cnt   <= '0;
        v_cnt   <= '0;
        rd_addr <= '0;
      end else if (state == rsp_pkg::S_DIST) begin
        f_cnt   <= f_last ? '0 : f_cnt + FW'(1);
        rd_addr <= rd_addr + VAW'(1);
      end else if (state == rsp_pkg::S_KWAIT && exp_done && !v_last) begin
        v_cnt <= v_cnt + VW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      fi_r  <= feature_index[FW-1:0];
      val_r <= value;
    end
    if (state == rsp_pkg::S_FEAT_WR) begin
      sq_dist <= '0;
      acc     <= {{4{intercept[31]}}, intercept, 12'd0};
    end else if (rd_vld) begin
      sq_dist <= sq_dist + 39'(dsq[31:0]);
    end
    if (state == rsp_pkg::S_GAMMA)
      t <= 55'(gamma) * 55'(sq_dist);
    if (state == rsp_pkg::S_KWAIT && exp_done) begin
      acc     <= acc + 48'(mac);
      sq_dist <= '0;
    end
    if (state == rsp_pkg::S_DEC)
      dec <= dsat;
    if (state == rsp_pkg::S_PMUL)
      pprod <= 64'(dec) * 64'(platt_a);
    if (state == rsp_pkg::S_PARG)
      e <= 49'($signed(pps[63:16])) - 49'(platt_b);
    if (state == rsp_pkg::S_PWAIT && exp_done)
      q <= exp_y;
    if (state == rsp_pkg::S_DWAIT && div_done)
      p <= (div_q > 17'd65535) ? 16'hFFFF : div_q[15:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == rsp_pkg::S_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rsp_pkg::S_OUT && out_free) begin
      probability <= p;
      decision    <= dec;
    end
  end

  rsp_exp_unit u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .x     (exp_x),
    .done  (exp_done),
    .y     (exp_y)
  );

  rsp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

`ifndef SYNTHESIS
  a_exp_done_waited: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> (state == rsp_pkg::S_KWAIT || state == rsp_pkg::S_PWAIT))
    else $error("exp result arrived outside a wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rsp_pkg::S_DWAIT)
    else $error("divider finished outside its wait state");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == rsp_pkg::S_OUT)
    else $error("result raised without a finished classification");

  a_dist_wrapped: assert property (@(posedge clk) disable iff (rst)
    state == rsp_pkg::S_DIST_END |-> f_cnt == '0)
    else $error("feature counter did not wrap at end of vector");
`endif

endmodule

/* design/rsp_exp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_exp_unit
// Three-stage exp(-x) for x in Q.16 (x <= 2^26): base-2 conversion, table
// lookup with linear interpolation, then the power-of-two shift. Q1.16 out.
// ----------------------------------------------------------------------------
module rsp_exp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [26:0] x,
  output logic        done,
  output logic [16:0] y
);

  logic [2:0]  vld;
  logic [26:0] z;
  logic [30:0] m;
  logic [4:0]  nsh;
  logic        zero;

  logic [57:0] zprod;
  logic [57:0] zsum;
  logic [10:0] n;
  logic [7:0]  idx;
  logic [7:0]  lo;
  logic [30:0] ta;
  logic [30:0] tb;
  logic [30:0] tdiff;
  logic [38:0] iprod;
  logic [38:0] isum;
  logic [44:0] ssum;
  logic [44:0] sres;

  // stage 1: z = x * log2(e), rounded to Q.16
  assign zprod = {31'd0, x} * {27'd0, rsp_pkg::LOG2E_Q30};
  assign zsum  = zprod + (58'd1 << 29);

  // stage 2: table and interpolation
  assign n     = z[26:16];
  assign idx   = z[15:8];
  assign lo    = z[7:0];
  assign ta    = rsp_pkg::EXP_TAB[idx];
  assign tb    = (idx != 8'hFF) ? rsp_pkg::EXP_TAB[8'(idx + 8'd1)]
                                : (rsp_pkg::EXP_TAB[0] >> 1);
  assign tdiff = ta - tb;
  assign iprod = {8'd0, tdiff} * {31'd0, lo};
  assign isum  = iprod + 39'd128;

  // stage 3: rounded right shift by n+14
  assign ssum = {14'd0, m} + (45'd1 << (6'(nsh) + 6'd13));
  assign sres = ssum >> (6'(nsh) + 6'd14);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    z    <= zsum[56:30];
    m    <= ta - isum[38:8];
    nsh  <= n[4:0];
    zero <= (n > 11'd30);
    y    <= zero ? 17'd0 : sres[16:0];
  end

  assign done = vld[2];

endmodule

/* design/rsp_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsp_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] num,
  input  logic [17:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [33:0] work;
  logic [17:0] rem;
  logic [18:0] trial;
  logic        fits;

  assign trial = {rem, work[33]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd34;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[32:0], fits};
      rem  <= fits ? 18'(trial - {1'b0, den}) : trial[17:0];
    end
  end

  assign quot = work[16:0];

endmodule
